@@ sv/sbo_pkg.sv @@
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared constants for the segment versus box overlap pipeline.
// ----------------------------------------------------------------------------
package sbo_pkg;

   // default coordinate width (signed Q16.16)
   localparam int COORD_WIDTH_DEF = 32;

   // extra bits for doubled sums and differences (end + start - min - max)
   localparam int DIFF_EXTRA = 3;

   // request to response latency in clock edges
   localparam int LATENCY = 5;

endpackage

@@ sv/sbo_cross_axis.sv @@
// ----------------------------------------------------------------------------
// sbo_cross_axis
// One cross-product separating axis: |l2_a*d2_b - l2_b*d2_a| against
// e2_a*al_b + e2_b*al_a, over two register stages.
// ----------------------------------------------------------------------------
module sbo_cross_axis #(
   parameter int DATA_WIDTH = sbo_pkg::COORD_WIDTH_DEF + sbo_pkg::DIFF_EXTRA
) (
   input  logic                         clock,
   input  logic signed [DATA_WIDTH-1:0] l2_a,
   input  logic signed [DATA_WIDTH-1:0] l2_b,
   input  logic signed [DATA_WIDTH-1:0] d2_a,
   input  logic signed [DATA_WIDTH-1:0] d2_b,
   input  logic signed [DATA_WIDTH-1:0] e2_a,
   input  logic signed [DATA_WIDTH-1:0] e2_b,
   input  logic signed [DATA_WIDTH-1:0] al_a,
   input  logic signed [DATA_WIDTH-1:0] al_b,
   output logic                         separates
);

   localparam int PW = 2 * DATA_WIDTH;

   logic signed [PW-1:0] cr_p_ff, cr_q_ff, lim_p_ff, lim_q_ff;
   logic signed [PW-1:0] cr_p_in, cr_q_in, lim_p_in, lim_q_in;
   logic signed [PW-1:0] cr_ff, lim_ff, cr_in, lim_in;
   logic signed [PW-1:0] cr_abs;

   // products, one multiplier each
   always_comb begin
      cr_p_in  = l2_a * d2_b;
      cr_q_in  = l2_b * d2_a;
      lim_p_in = e2_a * al_b;
      lim_q_in = e2_b * al_a;
   end

   always_ff @(posedge clock) begin
      cr_p_ff  <= cr_p_in;
      cr_q_ff  <= cr_q_in;
      lim_p_ff <= lim_p_in;
      lim_q_ff <= lim_q_in;
   end

   // cross component and its limit
   always_comb begin
      cr_in  = cr_p_ff - cr_q_ff;
      lim_in = lim_p_ff + lim_q_ff;
   end

   always_ff @(posedge clock) begin
      cr_ff  <= cr_in;
      lim_ff <= lim_in;
   end

   // axis separates when the magnitude exceeds the limit
   always_comb begin
      cr_abs    = cr_ff[PW-1] ? -cr_ff : cr_ff;
      separates = cr_abs > lim_ff;
   end

endmodule

@@ sv/segment_box_overlap_test.sv @@
// ----------------------------------------------------------------------------
// segment_box_overlap_test
// Separating-axis overlap test of a line segment against an axis-aligned box.
//
//   channel   ports                      handshake
//   request   req_box_*, req_seg_*       start, accepted when start && !busy
//   response  rsp_overlap                rsp_strobe, one cycle, always taken
//
// A request may enter on every clock; busy is never raised.
// Each response passes through the five register stages: differences, box
// axes, products, cross terms, compare.
// The widest step is the signed (COORD_WIDTH+3)-bit multiply per product.
// Reset clears the stage valid bits only; requests in flight are dropped.
// ----------------------------------------------------------------------------
module segment_box_overlap_test #(
   parameter int COORD_WIDTH = sbo_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_z,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_z,
   output logic                          rsp_strobe,
   output logic                          rsp_overlap
);

   localparam int DW = COORD_WIDTH + sbo_pkg::DIFF_EXTRA;

   logic accept;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_strobe_ff;

   // stage 1: doubled extents, directions and centre offsets
   logic signed [DW-1:0] e2_in [3];
   logic signed [DW-1:0] l2_in [3];
   logic signed [DW-1:0] d2_in [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] l2_ff [3];
   logic signed [DW-1:0] d2_ff [3];

   // stage 2: magnitudes and box axis test
   logic signed [DW-1:0] al_in [3];
   logic signed [DW-1:0] ad    [3];
   logic signed [DW-1:0] e2_s2_ff [3];
   logic signed [DW-1:0] l2_s2_ff [3];
   logic signed [DW-1:0] d2_s2_ff [3];
   logic signed [DW-1:0] al_ff [3];
   logic                 box_sep_in, box_sep2_ff, box_sep3_ff, box_sep4_ff;

   logic [2:0] cross_sep;
   logic       rsp_overlap_ff, rsp_overlap_in;

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // valid bits travel with the request
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         rsp_strobe_ff <= v4_ff;
      end
   end

   // doubled quantities, exact at coordinate width plus three
   always_comb begin
      e2_in[0] = DW'(req_box_max_x) - DW'(req_box_min_x);
      e2_in[1] = DW'(req_box_max_y) - DW'(req_box_min_y);
      e2_in[2] = DW'(req_box_max_z) - DW'(req_box_min_z);
      l2_in[0] = DW'(req_seg_end_x) - DW'(req_seg_start_x);
      l2_in[1] = DW'(req_seg_end_y) - DW'(req_seg_start_y);
      l2_in[2] = DW'(req_seg_end_z) - DW'(req_seg_start_z);
      d2_in[0] = DW'(req_seg_end_x) + DW'(req_seg_start_x)
               - DW'(req_box_min_x) - DW'(req_box_max_x);
      d2_in[1] = DW'(req_seg_end_y) + DW'(req_seg_start_y)
               - DW'(req_box_min_y) - DW'(req_box_max_y);
      d2_in[2] = DW'(req_seg_end_z) + DW'(req_seg_start_z)
               - DW'(req_box_min_z) - DW'(req_box_max_z);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e2_ff[i] <= e2_in[i];
         l2_ff[i] <= l2_in[i];
         d2_ff[i] <= d2_in[i];
      end
   end

   // box axes: separated when |d2| > e2 + |l2|
   always_comb begin
      box_sep_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         al_in[i] = l2_ff[i][DW-1] ? -l2_ff[i] : l2_ff[i];
         ad[i]    = d2_ff[i][DW-1] ? -d2_ff[i] : d2_ff[i];
         if (ad[i] > e2_ff[i] + al_in[i]) begin
            box_sep_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e2_s2_ff[i] <= e2_ff[i];
         l2_s2_ff[i] <= l2_ff[i];
         d2_s2_ff[i] <= d2_ff[i];
         al_ff[i]    <= al_in[i];
      end
      box_sep2_ff <= box_sep_in;
      box_sep3_ff <= box_sep2_ff;
      box_sep4_ff <= box_sep3_ff;
   end

   // cross axes: x uses (y, z), y uses (z, x), z uses (x, y)
   for (genvar a = 0; a < 3; a++) begin : g_cross
      localparam int IA = (a + 1) % 3;
      localparam int IB = (a + 2) % 3;

      sbo_cross_axis #(
         .DATA_WIDTH(DW)
      ) u_cross (
         .clock     (clock),
         .l2_a      (l2_s2_ff[IA]),
         .l2_b      (l2_s2_ff[IB]),
         .d2_a      (d2_s2_ff[IA]),
         .d2_b      (d2_s2_ff[IB]),
         .e2_a      (e2_s2_ff[IA]),
         .e2_b      (e2_s2_ff[IB]),
         .al_a      (al_ff[IA]),
         .al_b      (al_ff[IB]),
         .separates (cross_sep[a])
      );
   end

   // final verdict: overlap unless any axis separates
   assign rsp_overlap_in = !(box_sep4_ff || (|cross_sep));

   always_ff @(posedge clock) begin
      rsp_overlap_ff <= rsp_overlap_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_overlap = rsp_overlap_ff;

   // every response comes from a request accepted a fixed time before
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, sbo_pkg::LATENCY))
      else $error("response without matching request");

   // every accepted request yields a response
   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(sbo_pkg::LATENCY) rsp_strobe)
      else $error("request lost in pipeline");

   // a box axis separation always forces no overlap
   a_box_sep_wins: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && box_sep2_ff) |-> ##3 (rsp_strobe && !rsp_overlap))
      else $error("box axis separation not reported");

endmodule
